>>> rtl/core/mntl_pkg.sv
package mntl_pkg;

    // Pad count the block is built for by default
    localparam int NUM_PADS_DEF = 16;

    // Most flips one item may cause
    localparam int MAX_FLIPS = 16;
    localparam int FLIP_CNT_W = $clog2(MAX_FLIPS);

    // Width of the toggle mask field
    localparam int MASK_W = 16;

    // Command queue between front and back (power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Pad table reset contents
    localparam int PAD_BASE_NOTE = 60;
    localparam logic [6:0] PAD_DEF_VEL = 7'd100;
    localparam logic [3:0] PAD_DEF_CHAN = 4'd0;    // channel 1, stored as channel - 1

    // MIDI encoding
    localparam logic [3:0] ST_NOTE_ON_HI = 4'h9;
    localparam logic [3:0] ST_NOTE_OFF_HI = 4'h8;
    localparam logic [1:0] MIDI_FULL_LEN = 2'd3;
    localparam logic [4:0] MIDI_MAX_CHAN = 5'd16;

    typedef enum logic [1:0] {
        OP_MIDI   = 2'd0,
        OP_MASK   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_ALLOFF = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_PASS,
        CMD_NOTE,
        CMD_MASK,
        CMD_ALLOFF,
        CMD_WRITE
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } bk_state_t;

    typedef struct packed {
        logic [6:0] trig;
        logic [6:0] note;
        logic [6:0] vel;
        logic [3:0] chan;    // channel - 1
    } pad_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        st;
        logic [6:0]        d1;
        logic [6:0]        d2;
        logic [1:0]        len;
        logic [15:0]       pos;
        logic [MASK_W-1:0] mask;
        logic              wr_ok;
        logic [3:0]        idx;
        pad_t              entry;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage

>>> rtl/core/mntl_front.sv
module mntl_front #(
    parameter int NUM_PADS = mntl_pkg::NUM_PADS_DEF
) (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [7:0]                status_byte,
    input  logic [6:0]                data_one,
    input  logic [6:0]                data_two,
    input  logic [1:0]                msg_len,
    input  logic [15:0]               sample_pos,
    input  logic [15:0]               toggle_mask,
    input  logic [3:0]                pad_index,
    input  logic [6:0]                new_trigger,
    input  logic [6:0]                new_out_note,
    input  logic [6:0]                new_velocity,
    input  logic [4:0]                new_channel,
    input  mntl_pkg::qstat_t          qstat,
    output logic                      push,
    output mntl_pkg::cmd_t            cmd
);

    logic note_on;

    assign in_ready = !qstat.full;
    assign push = in_valid && in_ready;

    assign note_on = (status_byte[7:4] == mntl_pkg::ST_NOTE_ON_HI)
                     && (msg_len == mntl_pkg::MIDI_FULL_LEN)
                     && (data_two != 7'd0);

    always_comb
    begin
        cmd = '0;
        cmd.kind = mntl_pkg::CMD_PASS;
        case (mntl_pkg::op_t'(op))
            mntl_pkg::OP_MIDI:
            begin
                cmd.kind = note_on ? mntl_pkg::CMD_NOTE : mntl_pkg::CMD_PASS;
                // zero the bytes beyond the message length
                cmd.st = (msg_len >= 2'd1) ? status_byte : 8'd0;
                cmd.d1 = (msg_len >= 2'd2) ? data_one : 7'd0;
                cmd.d2 = (msg_len >= 2'd3) ? data_two : 7'd0;
                cmd.len = msg_len;
                cmd.pos = sample_pos;
            end
            mntl_pkg::OP_MASK:
            begin
                cmd.kind = mntl_pkg::CMD_MASK;
                cmd.mask = toggle_mask;
            end
            mntl_pkg::OP_WRITE:
            begin
                cmd.kind = mntl_pkg::CMD_WRITE;
                cmd.wr_ok = int'(pad_index) < NUM_PADS;
                cmd.idx = pad_index;
                cmd.entry.trig = new_trigger;
                cmd.entry.note = new_out_note;
                cmd.entry.vel = (new_velocity == 7'd0) ? 7'd1 : new_velocity;
                if (new_channel == 5'd0)
                begin
                    cmd.entry.chan = 4'd0;
                end
                else if (new_channel > mntl_pkg::MIDI_MAX_CHAN)
                begin
                    cmd.entry.chan = 4'd15;
                end
                else
                begin
                    cmd.entry.chan = 4'(new_channel - 5'd1);
                end
            end
            mntl_pkg::OP_ALLOFF:
            begin
                cmd.kind = mntl_pkg::CMD_ALLOFF;
            end
            default:
            begin
                cmd.kind = mntl_pkg::CMD_PASS;
            end
        endcase
    end

endmodule

>>> rtl/core/mntl_queue.sv
module mntl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mntl_pkg::cmd_t   cmd_in,
    input  logic             pop,
    output mntl_pkg::cmd_t   cmd_out,
    output mntl_pkg::qstat_t qstat
);

    mntl_pkg::cmd_t              slot_reg [mntl_pkg::QDEPTH];
    logic [mntl_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mntl_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mntl_pkg::QPTR_W:0]   count_reg, count_next;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full = (count_reg == (mntl_pkg::QPTR_W + 1)'(mntl_pkg::QDEPTH));
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        // pointers wrap on their own since the depth is a power of two
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> rtl/core/mntl_back.sv
module mntl_back #(
    parameter int NUM_PADS = mntl_pkg::NUM_PADS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mntl_pkg::cmd_t cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_status,
    output logic [6:0]     out_data_one,
    output logic [6:0]     out_data_two,
    output logic [1:0]     out_len,
    output logic [15:0]    out_sample_pos,
    output logic           last
);

    localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int CNT_W = mntl_pkg::FLIP_CNT_W;

    mntl_pkg::bk_state_t state_reg, state_next;
    mntl_pkg::pad_t      tbl_reg [NUM_PADS];
    mntl_pkg::pad_t      tbl_next [NUM_PADS];
    logic [NUM_PADS-1:0] latch_reg, latch_next;
    logic [NUM_PADS-1:0] set_reg, set_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_status_reg, out_status_next;
    logic [6:0]          out_data_one_reg, out_data_one_next;
    logic [6:0]          out_data_two_reg, out_data_two_next;
    logic [1:0]          out_len_reg, out_len_next;
    logic [15:0]         out_sample_pos_reg, out_sample_pos_next;
    logic                last_reg, last_next;

    logic                       can_emit;
    logic                       load;
    logic                       last_flag;
    logic                       flip_en;
    logic [PAD_W-1:0]           flip_idx;
    logic [15:0]                flip_pos;
    logic                       wr_en;
    logic                       match_hit;
    logic [PAD_W-1:0]           match_idx;
    logic [PAD_W-1:0]           low_idx;
    logic [NUM_PADS-1:0]        rest;
    logic [NUM_PADS+mntl_pkg::MASK_W-1:0] mask_wide;
    logic [NUM_PADS-1:0]        mask_ext;
    mntl_pkg::pad_t             sel_pad;
    logic                       sel_old;

    assign can_emit = !out_valid_reg || out_ready;

    // mask bits beyond the pads drop out here
    assign mask_wide = {{NUM_PADS{1'b0}}, cmd.mask};
    assign mask_ext = mask_wide[NUM_PADS-1:0];

    // lowest pad whose trigger equals the note
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = NUM_PADS - 1; i >= 0; i--)
        begin
            if (tbl_reg[i].trig == cmd.d1)
            begin
                match_hit = 1'b1;
                match_idx = PAD_W'(i);
            end
        end
    end

    // lowest pad still pending in the scan set
    always_comb
    begin
        low_idx = '0;
        for (int i = NUM_PADS - 1; i >= 0; i--)
        begin
            if (set_reg[i])
            begin
                low_idx = PAD_W'(i);
            end
        end
        rest = set_reg;
        rest[low_idx] = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        set_next = set_reg;
        cnt_next = cnt_reg;
        pop = 1'b0;
        load = 1'b0;
        last_flag = 1'b1;
        flip_en = 1'b0;
        flip_idx = low_idx;
        flip_pos = 16'd0;
        wr_en = 1'b0;
        case (state_reg)
            mntl_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (cmd.kind)
                        mntl_pkg::CMD_PASS:
                        begin
                            if (can_emit)
                            begin
                                pop = 1'b1;
                                load = 1'b1;
                            end
                        end
                        mntl_pkg::CMD_NOTE:
                        begin
                            if (can_emit)
                            begin
                                pop = 1'b1;
                                load = 1'b1;
                                if (match_hit)
                                begin
                                    flip_en = 1'b1;
                                    flip_idx = match_idx;
                                    flip_pos = cmd.pos;
                                end
                            end
                        end
                        mntl_pkg::CMD_MASK:
                        begin
                            pop = 1'b1;
                            set_next = mask_ext;
                            cnt_next = '0;
                            state_next = mntl_pkg::BK_SCAN;
                        end
                        mntl_pkg::CMD_ALLOFF:
                        begin
                            pop = 1'b1;
                            set_next = latch_reg;
                            cnt_next = '0;
                            state_next = mntl_pkg::BK_SCAN;
                        end
                        mntl_pkg::CMD_WRITE:
                        begin
                            pop = 1'b1;
                            wr_en = cmd.wr_ok;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            mntl_pkg::BK_SCAN:
            begin
                if (set_reg == '0)
                begin
                    state_next = mntl_pkg::BK_IDLE;
                end
                else if (can_emit)
                begin
                    load = 1'b1;
                    flip_en = 1'b1;
                    set_next = rest;
                    cnt_next = cnt_reg + 1'b1;
                    last_flag = (rest == '0)
                                || (cnt_reg == CNT_W'(mntl_pkg::MAX_FLIPS - 1));
                    if (last_flag)
                    begin
                        state_next = mntl_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mntl_pkg::BK_IDLE;
            end
        endcase
    end

    assign sel_pad = tbl_reg[flip_idx];
    assign sel_old = latch_reg[flip_idx];

    always_comb
    begin
        latch_next = latch_reg;
        tbl_next = tbl_reg;
        if (flip_en)
        begin
            latch_next[flip_idx] = !sel_old;
        end
        if (wr_en)
        begin
            latch_next[PAD_W'(cmd.idx)] = 1'b0;
            tbl_next[PAD_W'(cmd.idx)] = cmd.entry;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_one_next = out_data_one_reg;
        out_data_two_next = out_data_two_reg;
        out_len_next = out_len_reg;
        out_sample_pos_next = out_sample_pos_reg;
        last_next = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            last_next = last_flag;
            if (flip_en)
            begin
                // unlatched pad goes on, latched pad goes off
                out_status_next = {sel_old ? mntl_pkg::ST_NOTE_OFF_HI
                                           : mntl_pkg::ST_NOTE_ON_HI, sel_pad.chan};
                out_data_one_next = sel_pad.note;
                out_data_two_next = sel_old ? 7'd0 : sel_pad.vel;
                out_len_next = mntl_pkg::MIDI_FULL_LEN;
                out_sample_pos_next = flip_pos;
            end
            else
            begin
                out_status_next = cmd.st;
                out_data_one_next = cmd.d1;
                out_data_two_next = cmd.d2;
                out_len_next = cmd.len;
                out_sample_pos_next = cmd.pos;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mntl_pkg::BK_IDLE;
            set_reg <= '0;
            cnt_reg <= '0;
            latch_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PADS; i++)
            begin
                tbl_reg[i].trig <= 7'(mntl_pkg::PAD_BASE_NOTE + i);
                tbl_reg[i].note <= 7'(mntl_pkg::PAD_BASE_NOTE + i);
                tbl_reg[i].vel <= mntl_pkg::PAD_DEF_VEL;
                tbl_reg[i].chan <= mntl_pkg::PAD_DEF_CHAN;
            end
        end
        else
        begin
            state_reg <= state_next;
            set_reg <= set_next;
            cnt_reg <= cnt_next;
            latch_reg <= latch_next;
            out_valid_reg <= out_valid_next;
            tbl_reg <= tbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_one_reg <= out_data_one_next;
        out_data_two_reg <= out_data_two_next;
        out_len_reg <= out_len_next;
        out_sample_pos_reg <= out_sample_pos_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data_one = out_data_one_reg;
    assign out_data_two = out_data_two_reg;
    assign out_len = out_len_reg;
    assign out_sample_pos = out_sample_pos_reg;
    assign last = last_reg;

endmodule

>>> rtl/core/midi_note_toggle_latch.sv
// Pad latch for MIDI notes: a table of NUM_PADS pads, each with a latch bit.
// Input channel (in_valid/in_ready) takes one beat per item: a short MIDI
// message, a toggle mask, a pad write or an all-off request, selected by op.
// Output channel (out_valid/out_ready) gives result beats; last marks the
// final beat of an item. Pad writes and empty toggles give no beat at all.
// A MIDI item passes through the command queue and then the output
// register before it shows on the output.
// The back end takes a MIDI item or pad write from the head of the queue, a
// MIDI item only once the output can take a beat. A toggle mask or all-off
// first loads its pad set, then its scan flips one pad per cycle while the
// output can take a beat, up to sixteen flips. A two-entry command queue
// sits between the front end and the back end, so the input keeps taking
// beats while the back end works or waits on the output.
// Reset clears all latches and loads each pad i with trigger and output note
// 60+i, velocity 100, channel 1. Out of reset the block is ready at once.
// When the receiver stalls, the output register holds its beat, the back end
// stops sending beats, and in_ready drops once the queue fills.
module midi_note_toggle_latch #(
    parameter int NUM_PADS = mntl_pkg::NUM_PADS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_one,
    input  logic [6:0]  data_two,
    input  logic [1:0]  msg_len,
    input  logic [15:0] sample_pos,
    input  logic [15:0] toggle_mask,
    input  logic [3:0]  pad_index,
    input  logic [6:0]  new_trigger,
    input  logic [6:0]  new_out_note,
    input  logic [6:0]  new_velocity,
    input  logic [4:0]  new_channel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_status,
    output logic [6:0]  out_data_one,
    output logic [6:0]  out_data_two,
    output logic [1:0]  out_len,
    output logic [15:0] out_sample_pos,
    output logic        last
);

    mntl_pkg::cmd_t   front_cmd;
    mntl_pkg::cmd_t   back_cmd;
    mntl_pkg::qstat_t qstat;
    logic             push;
    logic             pop;

    // Classify the incoming beat and clamp pad write values
    mntl_front #(
        .NUM_PADS(NUM_PADS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .status_byte (status_byte),
        .data_one    (data_one),
        .data_two    (data_two),
        .msg_len     (msg_len),
        .sample_pos  (sample_pos),
        .toggle_mask (toggle_mask),
        .pad_index   (pad_index),
        .new_trigger (new_trigger),
        .new_out_note(new_out_note),
        .new_velocity(new_velocity),
        .new_channel (new_channel),
        .qstat       (qstat),
        .push        (push),
        .cmd         (front_cmd)
    );

    // Hold commands so front and back stall independently
    mntl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (front_cmd),
        .pop    (pop),
        .cmd_out(back_cmd),
        .qstat  (qstat)
    );

    // Match triggers, flip latches, update the table and drive result beats
    mntl_back #(
        .NUM_PADS(NUM_PADS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qstat.valid),
        .cmd           (back_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_status    (out_status),
        .out_data_one  (out_data_one),
        .out_data_two  (out_data_two),
        .out_len       (out_len),
        .out_sample_pos(out_sample_pos),
        .last          (last)
    );

    // A beat taken into an empty queue is visible to the back end next cycle
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !qstat.valid) |=> qstat.valid)
        else $error("queued command not visible to back end");

    // Short passed messages are always the only beat of their item
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_len != mntl_pkg::MIDI_FULL_LEN)) |-> last)
        else $error("short message beat not marked last");

    // Toggle and all-off beats carry position zero; MIDI items give one beat
    a_pos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_sample_pos != 16'd0)) |-> last)
        else $error("timestamped beat not marked last");

endmodule

>>> dv/midi_note_toggle_latch_tb.sv
module midi_note_toggle_latch_tb;

    localparam int PADS            = mntl_pkg::NUM_PADS_DEF;
    localparam int RANDOM_CMDS     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_MAX      = 10;
    localparam int IDLE_PCT        = 26;

    // One input beat, all fields side by side; op picks which ones matter
    typedef struct packed {
        mntl_pkg::op_t op;
        logic [7:0]  st;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  len;
        logic [15:0] pos;
        logic [15:0] mask;
        logic [3:0]  idx;
        logic [6:0]  trig;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [4:0]  chan;
    } pad_cmd_t;

    // One output beat
    typedef struct packed {
        logic [7:0]  st;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  len;
        logic [15:0] pos;
        logic        fin;
    } note_msg_t;

    // Pad table and latch bits mirrored beside the block; every accepted
    // command beat is turned into the note messages it must produce.
    class pad_latch_model;
        mntl_pkg::pad_t pads[PADS];
        bit        latched[PADS];
        note_msg_t due_msgs[$];
        int        errors;

        function new();
            errors = 0;
            for (int i = 0; i < PADS; i++)
            begin
                pads[i].trig = 7'(mntl_pkg::PAD_BASE_NOTE + i);
                pads[i].note = 7'(mntl_pkg::PAD_BASE_NOTE + i);
                pads[i].vel  = mntl_pkg::PAD_DEF_VEL;
                pads[i].chan = mntl_pkg::PAD_DEF_CHAN;
                latched[i]   = 1'b0;
            end
        endfunction

        function void report(string s);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%s", s);
        endfunction

        // Flip one pad and build the note-on or note-off it sends
        function note_msg_t flip(int p, logic [15:0] pos);
            note_msg_t m;
            latched[p] = !latched[p];
            m.st  = {latched[p] ? mntl_pkg::ST_NOTE_ON_HI : mntl_pkg::ST_NOTE_OFF_HI,
                     pads[p].chan};
            m.d1  = pads[p].note;
            m.d2  = latched[p] ? pads[p].vel : 7'd0;
            m.len = mntl_pkg::MIDI_FULL_LEN;
            m.pos = pos;
            m.fin = 1'b0;
            return m;
        endfunction

        function void take_cmd(pad_cmd_t c);
            note_msg_t  burst[$];
            note_msg_t  m;
            int         hit;
            logic [6:0] v;
            logic [4:0] ch;
            hit = -1;
            case (c.op)
                mntl_pkg::OP_MIDI:
                begin
                    if (c.st[7:4] == mntl_pkg::ST_NOTE_ON_HI
                        && c.len == mntl_pkg::MIDI_FULL_LEN && c.d2 != 7'd0)
                    begin
                        for (int i = 0; i < PADS; i++)
                            if (hit < 0 && pads[i].trig == c.d1)
                                hit = i;
                    end
                    if (hit >= 0)
                        burst.push_back(flip(hit, c.pos));
                    else
                    begin
                        m.st  = (c.len >= 2'd1) ? c.st : 8'd0;
                        m.d1  = (c.len >= 2'd2) ? c.d1 : 7'd0;
                        m.d2  = (c.len >= 2'd3) ? c.d2 : 7'd0;
                        m.len = c.len;
                        m.pos = c.pos;
                        m.fin = 1'b0;
                        burst.push_back(m);
                    end
                end
                mntl_pkg::OP_MASK:
                begin
                    for (int i = 0; i < PADS; i++)
                        if (c.mask[i])
                            burst.push_back(flip(i, 16'd0));
                end
                mntl_pkg::OP_ALLOFF:
                begin
                    for (int i = 0; i < PADS; i++)
                        if (latched[i])
                            burst.push_back(flip(i, 16'd0));
                end
                mntl_pkg::OP_WRITE:
                begin
                    v  = (c.vel == 7'd0) ? 7'd1 : c.vel;
                    ch = (c.chan == 5'd0) ? 5'd1 :
                         (c.chan > mntl_pkg::MIDI_MAX_CHAN) ? mntl_pkg::MIDI_MAX_CHAN
                                                            : c.chan;
                    pads[c.idx].trig = c.trig;
                    pads[c.idx].note = c.note;
                    pads[c.idx].vel  = v;
                    pads[c.idx].chan = 4'(ch - 5'd1);
                    latched[c.idx]   = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (burst.size() > 0)
                burst[burst.size() - 1].fin = 1'b1;
            foreach (burst[k])
                due_msgs.push_back(burst[k]);
        endfunction

        function void match_msg(note_msg_t got);
            note_msg_t want;
            if (due_msgs.size() == 0)
            begin
                report($sformatf("unexpected beat: st=%h d1=%h d2=%h len=%0d pos=%h last=%b",
                                 got.st, got.d1, got.d2, got.len, got.pos, got.fin));
                return;
            end
            want = due_msgs.pop_front();
            if (got.st !== want.st || got.d1 !== want.d1 || got.d2 !== want.d2 ||
                got.len !== want.len || got.pos !== want.pos || got.fin !== want.fin)
                report($sformatf({"beat mismatch: expected st=%h d1=%h d2=%h len=%0d pos=%h ",
                                  "last=%b, got st=%h d1=%h d2=%h len=%0d pos=%h last=%b"},
                                 want.st, want.d1, want.d2, want.len, want.pos, want.fin,
                                 got.st, got.d1, got.d2, got.len, got.pos, got.fin));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [1:0]  msg_len;
    logic [15:0] sample_pos;
    logic [15:0] toggle_mask;
    logic [3:0]  pad_index;
    logic [6:0]  new_trigger;
    logic [6:0]  new_out_note;
    logic [6:0]  new_velocity;
    logic [4:0]  new_channel;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_status;
    logic [6:0]  out_data_one;
    logic [6:0]  out_data_two;
    logic [1:0]  out_len;
    logic [15:0] out_sample_pos;
    logic        last;

    pad_latch_model board;
    bit             steady  = 1'b0;    // both sides stop idling while set
    bit             hold_go = 1'b0;    // ask the receiver for its long hold-off
    int             stall_cycles = 0;

    midi_note_toggle_latch u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .status_byte    (status_byte),
        .data_one       (data_one),
        .data_two       (data_two),
        .msg_len        (msg_len),
        .sample_pos     (sample_pos),
        .toggle_mask    (toggle_mask),
        .pad_index      (pad_index),
        .new_trigger    (new_trigger),
        .new_out_note   (new_out_note),
        .new_velocity   (new_velocity),
        .new_channel    (new_channel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_status     (out_status),
        .out_data_one   (out_data_one),
        .out_data_two   (out_data_two),
        .out_len        (out_len),
        .out_sample_pos (out_sample_pos),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Fill every field with noise, then set the op; callers override the
    // fields that matter so the ignored ones still toggle every bit.
    function automatic pad_cmd_t junk_cmd(mntl_pkg::op_t kind);
        pad_cmd_t    c;
        logic [95:0] r;
        r    = {$urandom, $urandom, $urandom};
        c    = r[$bits(pad_cmd_t)-1:0];
        c.op = kind;
        return c;
    endfunction

    function automatic pad_cmd_t midi_cmd(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                          logic [1:0] len, logic [15:0] pos);
        pad_cmd_t c;
        c     = junk_cmd(mntl_pkg::OP_MIDI);
        c.st  = st;
        c.d1  = d1;
        c.d2  = d2;
        c.len = len;
        c.pos = pos;
        return c;
    endfunction

    function automatic pad_cmd_t mask_cmd(logic [15:0] mask);
        pad_cmd_t c;
        c      = junk_cmd(mntl_pkg::OP_MASK);
        c.mask = mask;
        return c;
    endfunction

    function automatic pad_cmd_t write_cmd(logic [3:0] idx, logic [6:0] trig,
                                           logic [6:0] note, logic [6:0] vel,
                                           logic [4:0] chan);
        pad_cmd_t c;
        c      = junk_cmd(mntl_pkg::OP_WRITE);
        c.idx  = idx;
        c.trig = trig;
        c.note = note;
        c.vel  = vel;
        c.chan = chan;
        return c;
    endfunction

    // Offer one beat: idle a random number of cycles first, then hold valid
    // and the payload until the block takes it.
    task automatic send_cmd(pad_cmd_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= c.op;
        status_byte  <= c.st;
        data_one     <= c.d1;
        data_two     <= c.d2;
        msg_len      <= c.len;
        sample_pos   <= c.pos;
        toggle_mask  <= c.mask;
        pad_index    <= c.idx;
        new_trigger  <= c.trig;
        new_out_note <= c.note;
        new_velocity <= c.vel;
        new_channel  <= c.chan;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Receiver: stall at random, except once hold ready low for a long
    // stretch so the command queue fills and in_ready drops.
    initial
    begin : sink
        bit hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Sample both channels at the edge: note accepted commands, check
    // accepted messages, and end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.take_cmd('{op: mntl_pkg::op_t'(op), st: status_byte, d1: data_one,
                                 d2: data_two, len: msg_len, pos: sample_pos,
                                 mask: toggle_mask, idx: pad_index, trig: new_trigger,
                                 note: new_out_note, vel: new_velocity,
                                 chan: new_channel});
            if (out_valid && out_ready)
                board.match_msg('{st: out_status, d1: out_data_one, d2: out_data_two,
                                  len: out_len, pos: out_sample_pos, fin: last});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        pad_cmd_t c;
        int       pick;
        board = new();

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= mntl_pkg::OP_MIDI;
        status_byte  <= '0;
        data_one     <= '0;
        data_two     <= '0;
        msg_len      <= '0;
        sample_pos   <= '0;
        toggle_mask  <= '0;
        pad_index    <= '0;
        new_trigger  <= '0;
        new_out_note <= '0;
        new_velocity <= '0;
        new_channel  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Note-on latches pad 0, the same note unlatches it
        send_cmd(midi_cmd(8'h90, 7'd60, 7'd127, 2'd3, 16'hFFFF));
        send_cmd(midi_cmd(8'h90, 7'd60, 7'd1, 2'd3, 16'h0000));
        // Pass through: zero velocity, short messages, empty message, note-off
        send_cmd(midi_cmd(8'h90, 7'd61, 7'd0, 2'd3, 16'h1234));
        send_cmd(midi_cmd(8'h95, 7'd61, 7'd64, 2'd2, 16'h8001));
        send_cmd(midi_cmd(8'hF8, 7'd127, 7'd127, 2'd1, 16'h7FFE));
        send_cmd(midi_cmd(8'hFF, 7'd127, 7'd127, 2'd0, 16'hFFFF));
        send_cmd(midi_cmd(8'h80, 7'd60, 7'd64, 2'd3, 16'h00FF));
        // Note-on with no matching trigger
        send_cmd(midi_cmd(8'h9F, 7'd0, 7'd1, 2'd3, 16'hFF00));
        // Duplicate trigger on pad 15 with velocity and channel clamped up;
        // the lowest pad still wins
        send_cmd(write_cmd(4'd15, 7'd60, 7'd0, 7'd0, 5'd0));
        send_cmd(midi_cmd(8'h90, 7'd60, 7'd50, 2'd3, 16'h0001));
        // Rewrite pad 0 while latched: clears its latch, channel clamps to 16
        send_cmd(write_cmd(4'd0, 7'd5, 7'd127, 7'd127, 5'd31));
        send_cmd(midi_cmd(8'h90, 7'd60, 7'd90, 2'd3, 16'h0002));
        send_cmd(midi_cmd(8'h9A, 7'd5, 7'd127, 2'd3, 16'h0003));
        send_cmd(write_cmd(4'd3, 7'd127, 7'd0, 7'd64, 5'd17));
        send_cmd(midi_cmd(8'h90, 7'd127, 7'd1, 2'd3, 16'h0004));
        // Full mask, empty mask, all-off with and without latched pads
        send_cmd(mask_cmd(16'hFFFF));
        send_cmd(mask_cmd(16'h0000));
        send_cmd(junk_cmd(mntl_pkg::OP_ALLOFF));
        send_cmd(junk_cmd(mntl_pkg::OP_ALLOFF));
        // Latch the end pads, unlatch one by a write, all-off drops the other
        send_cmd(mask_cmd(16'h8001));
        send_cmd(write_cmd(4'd0, 7'd60, 7'd60, 7'd100, 5'd1));
        send_cmd(junk_cmd(mntl_pkg::OP_ALLOFF));
        // Sixteen flips on, sixteen flips off
        send_cmd(mask_cmd(16'hFFFF));
        send_cmd(junk_cmd(mntl_pkg::OP_ALLOFF));

        // Random part: mostly note-ons aimed at the trigger notes so pads keep
        // latching, with noise, masks, pad writes and all-off mixed in.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            steady = (n >= 150 && n < 210);
            if (n == 60)
                hold_go = 1'b1;
            pick = $urandom_range(99);
            if (pick < 52)
                c = midi_cmd({mntl_pkg::ST_NOTE_ON_HI, 4'($urandom)},
                             ($urandom_range(99) < 75) ? board.pads[$urandom_range(PADS - 1)].trig
                                                       : 7'($urandom),
                             7'($urandom_range(127, 1)), mntl_pkg::MIDI_FULL_LEN,
                             16'($urandom));
            else if (pick < 66)
                c = midi_cmd(8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom),
                             16'($urandom));
            else if (pick < 82)
            begin
                case ($urandom_range(3))
                    0: c = mask_cmd(16'(1 << $urandom_range(15)));
                    1: c = mask_cmd(($urandom_range(1)) ? 16'hFFFF : 16'h0000);
                    default: c = mask_cmd(16'($urandom));
                endcase
            end
            else if (pick < 93)
                c = write_cmd(4'($urandom),
                              ($urandom_range(99) < 75) ? 7'($urandom_range(80, 55))
                                                        : 7'($urandom),
                              7'($urandom),
                              ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom),
                              5'($urandom));
            else
                c = junk_cmd(mntl_pkg::OP_ALLOFF);
            send_cmd(c);
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        // Drain: wait for every owed message, then watch for strays
        @(posedge clk);
        while (board.due_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
